>>> rtl/cht_pkg.sv
// Shared types and constants of the counting hash table.
package cht_pkg;

   localparam int unsigned ENTRIES_DEFAULT  = 256;
   localparam int unsigned KEY_BITS_DEFAULT = 32;
   localparam int unsigned REQ_TYPE_BITS    = 2;
   localparam int unsigned KEY_PORT_BITS    = 32;
   localparam int unsigned COUNT_BITS       = 32;
   localparam int unsigned STATUS_BITS      = 3;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FIND   = 2'd2,
      REQ_SPARE  = 2'd3
   } req_type_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED    = 3'd0,
      ST_INCREMENTED = 3'd1,
      ST_REMOVED     = 3'd2,
      ST_DECREMENTED = 3'd3,
      ST_NOT_FOUND   = 3'd4,
      ST_FOUND       = 3'd5,
      ST_FULL        = 3'd6,
      ST_SPARE       = 3'd7
   } status_type;

   // Search word that travels down the chain of cells
   typedef struct packed {
      logic                  live;     // a search is in flight at this cell
      logic                  hit;      // key already matched upstream
      logic                  free;     // a free cell was seen upstream
      logic [COUNT_BITS-1:0] count;    // count of the matching cell
   } probe_type;

   // Command broadcast to every cell at the end of a search
   typedef struct packed {
      logic                  write_new;  // claim the first free cell
      logic                  bump_up;    // increment the matching cell
      logic                  bump_down;  // decrement the matching cell
      logic                  drop;       // invalidate the matching cell
   } update_type;

endpackage

>>> rtl/cht_cell.sv
// One storage cell of the chain: holds an entry and passes the search word on.
module cht_cell #(
   parameter int unsigned KEY_BITS = cht_pkg::KEY_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [cht_pkg::COUNT_BITS-1:0] initial_count,
   input  logic                          start,
   input  cht_pkg::probe_type            probe_i,
   output cht_pkg::probe_type            probe_o,
   input  cht_pkg::update_type           update
);
   import cht_pkg::*;

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  match_ff, match_in;
   logic                  claim_ff, claim_in;
   probe_type             probe_ff, probe_in;

   // Compare against the stored key and fold the result into the search word
   always_comb begin
      probe_in = probe_i;
      if (probe_i.live && valid_ff && key_ff == key) begin
         probe_in.hit   = 1'b1;
         probe_in.count = count_ff;
      end
      if (probe_i.live && !valid_ff) probe_in.free = 1'b1;
   end

   // Mark this cell as the match or as the first free cell of the search
   always_comb begin
      match_in = match_ff;
      claim_in = claim_ff;
      if (start) begin
         match_in = 1'b0;
         claim_in = 1'b0;
      end
      if (probe_i.live && valid_ff && key_ff == key) match_in = 1'b1;
      if (probe_i.live && !valid_ff && !probe_i.free) claim_in = 1'b1;
   end

   // Apply the update command chosen at the end of the search
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      if (update.write_new && claim_ff && !valid_ff) begin
         valid_in = 1'b1;
         key_in   = key;
         count_in = (initial_count == '0) ? COUNT_BITS'(1) : initial_count;
      end
      if (match_ff && valid_ff) begin
         if (update.bump_up && count_ff != '1) count_in = count_ff + 1'b1;
         if (update.bump_down) count_in = count_ff - 1'b1;
         if (update.drop) valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         claim_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         claim_ff <= claim_in;
         probe_ff <= probe_in;
      end
      key_ff   <= key_in;
      count_ff <= count_in;
   end

   assign probe_o = probe_ff;

endmodule

>>> rtl/cht_chain.sv
// Row of storage cells with the search word rippling from cell to cell.
module cht_chain #(
   parameter int unsigned ENTRIES  = cht_pkg::ENTRIES_DEFAULT,
   parameter int unsigned KEY_BITS = cht_pkg::KEY_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [cht_pkg::COUNT_BITS-1:0] initial_count,
   input  logic                          start,
   input  cht_pkg::update_type           update,
   output cht_pkg::probe_type            probe_tail
);
   import cht_pkg::*;

   probe_type probe [ENTRIES+1];

   // Launch a fresh search word at the head
   always_comb begin
      probe[0]       = '0;
      probe[0].live  = start;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cht_cell #(.KEY_BITS(KEY_BITS)) u_cell (
         .clock(clock), .reset(reset), .key(key), .initial_count(initial_count),
         .start(start), .probe_i(probe[i]), .probe_o(probe[i+1]),
         .update(update)
      );
   end

   assign probe_tail = probe[ENTRIES];

endmodule

>>> rtl/counting_hash_table.sv
// Top level of the counting hash table: request control around the cell chain.
// One request at a time: a new request is taken only back in the idle state.
// A registered start launches the search, the search word walks one cell per cycle
// down the chain, and the apply step then broadcasts the update to every cell.
// Reset clears every valid bit and the occupancy at once; no clearing pass.
// The result register frees the input; only the apply step waits for it.
module counting_hash_table #(
   parameter int unsigned ENTRIES  = cht_pkg::ENTRIES_DEFAULT,
   parameter int unsigned KEY_BITS = cht_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cht_pkg::REQ_TYPE_BITS-1:0] req_type,
   input  logic [cht_pkg::KEY_PORT_BITS-1:0] req_key,
   input  logic [cht_pkg::COUNT_BITS-1:0]    req_initial_count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cht_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [cht_pkg::COUNT_BITS-1:0]    rsp_count
);
   import cht_pkg::*;

   localparam int unsigned OCC_BITS = $clog2(ENTRIES + 1);
   localparam int unsigned KB = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_APPLY  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   req_type_type             op_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [COUNT_BITS-1:0]    init_ff;
   logic [OCC_BITS-1:0]      occ_ff, occ_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     start_ff;
   logic                     start;
   probe_type                tail;
   probe_type                tail_ff;
   update_type               update;
   logic                     req_fire, rsp_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign start     = start_ff;

   cht_chain #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_chain (
      .clock(clock), .reset(reset), .key(key_ff), .initial_count(init_ff),
      .start(start), .update(update), .probe_tail(tail)
   );

   // Decide the outcome once the search word leaves the last cell
   always_comb begin
      update       = '0;
      state_in     = state_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      count_in     = count_ff;
      case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_SEARCH;
         S_SEARCH: if (tail.live) state_in = S_APPLY;
         S_APPLY: begin
            // Hold the apply step while the previous result word waits
            if (!(rsp_valid_ff && !rsp_ready)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               case (op_ff)
                  REQ_INSERT: begin
                     if (tail_ff.hit) begin
                        update.bump_up = 1'b1;
                        status_in      = ST_INCREMENTED;
                        count_in       = (tail_ff.count == '1) ? tail_ff.count
                                                               : tail_ff.count + 1'b1;
                     end else if (!tail_ff.free) begin
                        status_in = ST_FULL;
                     end else begin
                        update.write_new = 1'b1;
                        status_in        = ST_INSERTED;
                        count_in         = (init_ff == '0) ? COUNT_BITS'(1) : init_ff;
                        occ_in           = occ_ff + 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     if (!tail_ff.hit) begin
                        status_in = ST_NOT_FOUND;
                     end else if (tail_ff.count <= COUNT_BITS'(1)) begin
                        update.drop = 1'b1;
                        status_in   = ST_REMOVED;
                        occ_in      = occ_ff - 1'b1;
                     end else begin
                        update.bump_down = 1'b1;
                        status_in        = ST_DECREMENTED;
                        count_in         = tail_ff.count - 1'b1;
                     end
                  end
                  default: begin
                     status_in = tail_ff.hit ? ST_FOUND : ST_NOT_FOUND;
                     count_in  = tail_ff.hit ? tail_ff.count : '0;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= req_fire;
      end
      status_ff <= status_in;
      count_ff  <= count_in;
      if (tail.live) tail_ff <= tail;
      if (req_fire) begin
         op_ff   <= req_type_type'(req_type);
         key_ff  <= KEY_BITS'(req_key[KB-1:0]);
         init_ff <= req_initial_count;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

   // Occupancy never exceeds the number of cells
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(ENTRIES)) else $error("occupancy overflow");
   // A new entry is only written when a free cell was seen
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      update.write_new |-> tail_ff.free) else $error("insert without free cell");
   // A result word is valid in the cycle after every apply-state cycle
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |=> rsp_valid_ff) else $error("result missing");
   // No request is taken outside the idle state
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("accept while busy");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the counting hash table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cht_pkg::*;

   localparam int unsigned SLOTS = ENTRIES_DEFAULT;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [REQ_TYPE_BITS-1:0]  req_type;
   logic [KEY_PORT_BITS-1:0]  req_key;
   logic [COUNT_BITS-1:0]     req_initial_count;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [COUNT_BITS-1:0]     rsp_count;

   counting_hash_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_key(req_key), .req_initial_count(req_initial_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_count(rsp_count)
   );

   typedef struct {
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } answer_type;

   typedef struct {
      req_type_type          op;
      logic [31:0]           key;
      logic [31:0]           init;
      bit                    typed;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } row_type;

   // Shadow copy of the store
   logic [31:0]           shadow_key   [SLOTS];
   logic [COUNT_BITS-1:0] shadow_count [SLOTS];
   bit                    shadow_valid [SLOTS];
   int unsigned           shadow_fill;

   answer_type  answers_due[$];
   int unsigned errors;
   int unsigned words_out;
   int unsigned burst_left;
   bit          holdoff_done;
   row_type     directed[16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int find_slot(input logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   // Apply one request to the shadow store and return its answer
   function automatic answer_type apply_request(input req_type_type op, input logic [31:0] k,
                                                input logic [31:0] init);
      answer_type a;
      int s;
      int f;
      s = find_slot(k);
      a.count = '0;
      case (op)
         REQ_INSERT: begin
            if (s >= 0) begin
               if (shadow_count[s] != COUNT_TOP) shadow_count[s]++;
               a.status = ST_INCREMENTED;
               a.count  = shadow_count[s];
            end else if (shadow_fill >= SLOTS) begin
               a.status = ST_FULL;
            end else begin
               f = 0;
               while (shadow_valid[f]) f++;
               shadow_valid[f] = 1'b1;
               shadow_key[f]   = k;
               shadow_count[f] = (init == 0) ? 1 : init;
               shadow_fill++;
               a.status = ST_INSERTED;
               a.count  = shadow_count[f];
            end
         end
         REQ_REMOVE: begin
            if (s < 0) begin
               a.status = ST_NOT_FOUND;
            end else if (shadow_count[s] <= 1) begin
               shadow_valid[s] = 1'b0;
               shadow_fill--;
               a.status = ST_REMOVED;
            end else begin
               shadow_count[s]--;
               a.status = ST_DECREMENTED;
               a.count  = shadow_count[s];
            end
         end
         default: begin
            // find, and the spare code which behaves as find
            if (s >= 0) begin
               a.status = ST_FOUND;
               a.count  = shadow_count[s];
            end else begin
               a.status = ST_NOT_FOUND;
            end
         end
      endcase
      return a;
   endfunction

   // Offer one word, hold until accepted, then log its answer
   task automatic send(input row_type r);
      answer_type a;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_valid         = 1'b1;
      req_type          = r.op;
      req_key           = r.key;
      req_initial_count = r.init;
      do @(posedge clock); while (!req_ready);
      a = apply_request(r.op, r.key, r.init);
      if (r.typed) begin
         if (a.status != r.status || a.count != r.count)
            report("shadow store disagrees with table row", a.count, r.count);
         a.status = r.status;
         a.count  = r.count;
      end
      answers_due.push_back(a);
   endtask

   function automatic row_type mk(input req_type_type op, input logic [31:0] k,
                                  input logic [31:0] init);
      row_type r;
      r.op = op; r.key = k; r.init = init; r.typed = 1'b0;
      r.status = ST_SPARE; r.count = '0;
      return r;
   endfunction

   function automatic logic [31:0] rand_init();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return COUNT_TOP;
         2:       return $urandom();
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   // Check each result word against the oldest answer due
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (answers_due.size() == 0) begin
            report("result word with nothing due", rsp_count, 0);
         end else begin
            a = answers_due.pop_front();
            if (rsp_status != a.status) report("status", rsp_status, a.status);
            if (rsp_count != a.count) report("count", rsp_count, a.count);
         end
      end
   end

   // Receiver stalls on its own pattern, with one long hold-off
   initial begin
      int unsigned mode;
      rsp_ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(negedge clock);
            if (!holdoff_done && words_out >= 300) begin
               holdoff_done = 1'b1;
               rsp_ready = 1'b0;
               repeat (1500) @(negedge clock);
            end
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = ($urandom_range(0, 3) != 0);
               2:       rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = $urandom_range(0, 1);
            endcase
         end
      end
   end

   initial begin
      logic [31:0] pool[16];
      int unsigned picks;
      row_type r;
      errors = 0; words_out = 0; burst_left = 0; holdoff_done = 1'b0;
      shadow_fill = 0;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_FIND;
      req_key = '0;
      req_initial_count = '0;

      directed = '{
         '{REQ_FIND,   32'h0,        32'h0,        1, ST_NOT_FOUND,   32'h0},
         '{REQ_INSERT, 32'h0,        32'h0,        1, ST_INSERTED,    32'h1},
         '{REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_INSERTED,    32'hFFFFFFFF},
         '{REQ_INSERT, 32'hFFFFFFFF, 32'h1,        1, ST_INCREMENTED, 32'hFFFFFFFF},
         '{REQ_REMOVE, 32'hFFFFFFFF, 32'h0,        1, ST_DECREMENTED, 32'hFFFFFFFE},
         '{REQ_FIND,   32'hFFFFFFFF, 32'h0,        1, ST_FOUND,       32'hFFFFFFFE},
         '{REQ_SPARE,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_FOUND,       32'hFFFFFFFE},
         '{REQ_INSERT, 32'h0,        32'h5,        1, ST_INCREMENTED, 32'h2},
         '{REQ_REMOVE, 32'h0,        32'h0,        1, ST_DECREMENTED, 32'h1},
         '{REQ_REMOVE, 32'h0,        32'h0,        1, ST_REMOVED,     32'h0},
         '{REQ_REMOVE, 32'h0,        32'h0,        1, ST_NOT_FOUND,   32'h0},
         '{REQ_SPARE,  32'h0,        32'h0,        1, ST_NOT_FOUND,   32'h0},
         '{REQ_INSERT, 32'h80000000, 32'h1,        1, ST_INSERTED,    32'h1},
         '{REQ_REMOVE, 32'h80000000, 32'h0,        1, ST_REMOVED,     32'h0},
         '{REQ_INSERT, 32'h5555AAAA, 32'hAAAA5555, 1, ST_INSERTED,    32'hAAAA5555},
         '{REQ_FIND,   32'hAAAA5555, 32'h0,        1, ST_NOT_FOUND,   32'h0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows
      foreach (directed[i]) send(directed[i]);

      // Mixed traffic on a small key pool so hits are common
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < 320; n++) begin
         if (n % 80 == 79) pool[$urandom_range(0, 15)] = $urandom();
         send(mk(req_type_type'($urandom_range(0, 3)), pool[$urandom_range(0, 15)],
                 rand_init()));
      end

      // Fill the store to capacity
      while (shadow_fill < SLOTS)
         send(mk(REQ_INSERT, $urandom(), $urandom_range(0, 3)));

      // Full store: new keys are refused, present keys still count up
      for (int n = 0; n < 40; n++) begin
         if ($urandom_range(0, 1)) r = mk(REQ_INSERT, $urandom(), rand_init());
         else r = mk(REQ_INSERT, shadow_key[$urandom_range(0, SLOTS - 1)], 1);
         send(r);
      end

      // Drain: removes and finds on stored keys, odd misses mixed in
      picks = 0;
      while (picks < 320) begin
         int s;
         s = $urandom_range(0, SLOTS - 1);
         if (shadow_valid[s] || $urandom_range(0, 9) == 0) begin
            picks++;
            send(mk(($urandom_range(0, 3) == 0) ? REQ_FIND : REQ_REMOVE,
                    shadow_valid[s] ? shadow_key[s] : $urandom(), $urandom()));
         end
      end

      // Noise
      for (int n = 0; n < 150; n++)
         send(mk(req_type_type'($urandom_range(0, 3)),
                 ($urandom_range(0, 1)) ? pool[$urandom_range(0, 15)] : $urandom(),
                 rand_init()));

      @(negedge clock);
      req_valid = 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
